@@ src/mh2_pkg.sv @@
// Shared types, constants and helpers for the MurmurHash2 stream block.
// Used by mh2_front, mh2_queue, mh2_back and murmur2_hash_stream_top.
package mh2_pkg;

    localparam logic [31:0] MIX_M        = 32'h5bd1e995;
    localparam int          MIX_R        = 24;
    localparam int          FIN_SHIFT_A  = 13;
    localparam int          FIN_SHIFT_B  = 15;

    localparam logic [15:0] LENGTH_RESET = 16'd32;
    localparam logic [31:0] SEED_RESET   = 32'd97;

    localparam int          QUEUE_DEPTH  = 4;
    localparam int          QUEUE_AW     = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic REG_MESSAGE_LENGTH = 1'b0;
    localparam logic REG_HASH_SEED      = 1'b1;

    typedef enum logic [1:0] {
        KIND_FULL,
        KIND_PARTIAL,
        KIND_NONE
    } t_kind;

    typedef struct packed {
        logic [31:0] word;
        t_kind       kind;
        logic [1:0]  nbytes;
        logic        last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_FIN,
        S_OUT
    } t_back_state;

    function automatic logic [31:0] byte_mask(input logic [1:0] nbytes);
        logic [31:0] mask;
        case (nbytes)
            2'd3:    mask = 32'h00ffffff;
            2'd2:    mask = 32'h0000ffff;
            default: mask = 32'h000000ff;
        endcase
        return mask;
    endfunction

endpackage

@@ src/mh2_front.sv @@
// Front end: accepts message words, counts bytes and tags each word.
// Depends on mh2_pkg.
module mh2_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [31:0]   i_data_word,
    input  logic          i_reload,
    input  logic [15:0]   i_length,
    input  logic          i_queue_full,
    output logic          o_push,
    output mh2_pkg::t_item o_item
);
    import mh2_pkg::*;

    logic [15:0] r_remaining;
    logic [15:0] n_remaining;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_item.word   = i_data_word;
        o_item.nbytes = r_remaining[1:0];
        if (r_remaining >= 16'd4) begin
            o_item.kind = KIND_FULL;
            o_item.last = (r_remaining == 16'd4);
        end else if (r_remaining != 16'd0) begin
            o_item.kind = KIND_PARTIAL;
            o_item.last = 1'b1;
        end else begin
            o_item.kind = KIND_NONE;
            o_item.last = 1'b1;
        end
    end

    always_comb begin
        n_remaining = r_remaining;
        if (i_reload) begin
            n_remaining = i_length;
        end else if (o_push) begin
            n_remaining = o_item.last ? i_length : (r_remaining - 16'd4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= LENGTH_RESET;
        end else begin
            r_remaining <= n_remaining;
        end
    end

endmodule

@@ src/mh2_queue.sv @@
// Short register queue of tagged words between front and back.
// Depends on mh2_pkg.
module mh2_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  mh2_pkg::t_item           i_item,
    input  logic                     i_pop,
    output mh2_pkg::t_item           o_item,
    output logic                     o_valid,
    output logic                     o_full,
    output logic [mh2_pkg::QUEUE_AW:0] o_count
);
    import mh2_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr;
    logic [QUEUE_AW-1:0]  r_rd;
    logic [QUEUE_AW:0]    r_count;

    assign o_item  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ src/mh2_back.sv @@
// Back end: mixes each word into the hash, finalizes and holds the result.
// Depends on mh2_pkg.
module mh2_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  mh2_pkg::t_item       i_item,
    output logic                 o_pop,
    input  logic                 i_reload,
    input  logic [31:0]          i_start_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_hash_value,
    output mh2_pkg::t_back_state o_state
);
    import mh2_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_item       r_item;
    t_item       n_item;
    logic [31:0] r_h;
    logic [31:0] n_h;
    logic [31:0] r_k;
    logic [31:0] n_k;
    logic [31:0] r_out_hash;
    logic        r_out_valid;
    logic        out_load;

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;
    assign o_state      = r_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_reload && i_item_valid) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_state = (r_item.kind == KIND_FULL) ? S_MUL2 : S_FIN;
            end
            S_MUL2: begin
                n_state = r_item.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = (r_state == S_IDLE) && !i_reload && i_item_valid;
        out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_h    = r_h;
        n_k    = r_k;
        n_item = r_item;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_item = i_item;
                end
            end
            S_MUL1: begin
                if (r_item.kind == KIND_FULL) begin
                    n_k = 32'(r_item.word * MIX_M);
                    n_h = 32'(r_h * MIX_M);
                end else if (r_item.kind == KIND_PARTIAL) begin
                    n_h = 32'((r_h ^ (r_item.word & byte_mask(r_item.nbytes))) * MIX_M);
                end
            end
            S_MUL2: begin
                n_h = r_h ^ 32'((r_k ^ (r_k >> MIX_R)) * MIX_M);
            end
            S_FIN: begin
                n_h = 32'((r_h ^ (r_h >> FIN_SHIFT_A)) * MIX_M);
            end
            S_OUT: begin
                // start the next message once the hash leaves
                if (out_load) begin
                    n_h = i_start_value;
                end
            end
            default: begin
                n_h = r_h;
            end
        endcase
        if (i_reload) begin
            n_h = i_start_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_k    <= n_k;
        if (out_load) begin
            r_out_hash <= r_h ^ (r_h >> FIN_SHIFT_B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= SEED_RESET ^ {16'd0, LENGTH_RESET};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ src/murmur2_hash_stream_top.sv @@
// MurmurHash2 (32-bit) stream hasher: front counter, word queue, mixing back end.
// A result is registered after its last word passes the pop, multiply, finalize and
// output steps (no second multiply for a partial word), with the back end idle and
// the output register free; output waits while the previous hash waits for the sink.
// A full word passes pop and two multiply steps; the next is popped only from idle.
// Reset (synchronous, active low): length 32, seed 97, hash 97 xor 32, queue empty.
module murmur2_hash_stream_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_hash_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);
    import mh2_pkg::*;

    logic [15:0]       r_length;
    logic [15:0]       n_length;
    logic [31:0]       r_seed;
    logic [31:0]       n_seed;
    logic [31:0]       start_value;
    logic              push;
    t_item             front_item;
    t_item             queue_item;
    logic              queue_valid;
    logic              queue_full;
    logic [QUEUE_AW:0] queue_count;
    logic              pop;
    t_back_state       back_state;

    always_comb begin
        n_length = r_length;
        n_seed   = r_seed;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MESSAGE_LENGTH: n_length = i_cfg_wdata[15:0];
                REG_HASH_SEED:      n_seed   = i_cfg_wdata;
                default:            n_seed   = r_seed;
            endcase
        end
    end

    assign start_value = n_seed ^ {16'd0, n_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LENGTH_RESET;
            r_seed   <= SEED_RESET;
        end else begin
            r_length <= n_length;
            r_seed   <= n_seed;
        end
    end

    mh2_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .i_reload     (i_cfg_we),
        .i_length     (n_length),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    mh2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_valid (queue_valid),
        .o_full  (queue_full),
        .o_count (queue_count)
    );

    mh2_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (queue_valid),
        .i_item        (queue_item),
        .o_pop         (pop),
        .i_reload      (i_cfg_we),
        .i_start_value (start_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hash_value  (o_hash_value),
        .o_state       (back_state)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("word queue count beyond depth");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(back_state == S_OUT))
        else $error("result valid without finalize step");

    a_idle_takes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_state == S_IDLE && queue_valid && !i_cfg_we) |=> (back_state == S_MUL1))
        else $error("back end idle with a queued word");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> queue_valid)
        else $error("pop from empty word queue");

endmodule
